>>> src/icnt_pkg.sv
// ----------------------------------------------------------------------------
// icnt_pkg
// Shared constants, payload types and controller codes for the inversion
// counter.
// ----------------------------------------------------------------------------
package icnt_pkg;

	localparam int DEPTH      = 1024;
	localparam int VALUE_BITS = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int INV_W      = 19;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic                         last;
	} in_t;

	typedef struct packed {
		logic [INV_W-1:0] inversions;
		logic             overflow;
	} out_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PASS,
		ST_BLK,
		ST_MERGE,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // store incoming element
		logic start;     // first pass, run width one
		logic pass_init; // rewind to first block of the pass
		logic blk_init;  // set up run bounds, prime both heads
		logic step;      // emit one merged element
		logic pass_adv;  // double run width, swap stores
		logic finish;    // latch result, clear for next sequence
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pass_done; // run width covers whole sequence
		logic last_blk;  // current block is the final one of the pass
		logic blk_end;   // this step writes the block's last element
		logic out_busy;  // result register still held
	} sts_t;

endpackage

>>> src/inversion_counter_core.sv
// ----------------------------------------------------------------------------
// inversion_counter_core
// Merge-sort inversion counter over one sequence of signed values.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle until the one marked last; up to DEPTH are
// stored and any beyond that are dropped and flag overflow. The block then
// runs bottom-up merge passes, ping-ponging between two dual-read RAMs, and
// counts inversions (ties are not counted) as right-run elements overtake the
// left run. Each pass enters ST_PASS once, then per block ST_BLK for setup and
// ST_MERGE with one merge step per element; merging does one step per cycle,
// bounded by the RAM read ports. Input is not taken while merging. The result
// sits in an output register, so loading of the next sequence overlaps a
// result that has not yet been transferred.
module inversion_counter_core
	import icnt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	cmd_t cmd;
	sts_t sts;

	icnt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_data.last),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	icnt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

>>> src/icnt_ram.sv
// ----------------------------------------------------------------------------
// icnt_ram
// Generic single write, dual read RAM with registered read data.
// ----------------------------------------------------------------------------
module icnt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

>>> src/icnt_datapath.sv
// ----------------------------------------------------------------------------
// icnt_datapath
// Element stores, merge indices, inversion accumulator and result register.
// ----------------------------------------------------------------------------
module icnt_datapath
	import icnt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output sts_t sts,
	input  in_t  in_data,
	output out_t out_data,
	output logic out_valid,
	input  logic out_ready
);

	localparam logic [VALUE_BITS-1:0] SIGN_FLIP = {1'b1, {(VALUE_BITS-1){1'b0}}};

	logic [CNT_W-1:0] n_q, w_q, lo_q, mid_q, hi_q, i_q, j_q, k_q;
	logic [INV_W-1:0] acc_q;
	logic             ovf_q;
	logic             pass_q; // 0: A is source, 1: B is source
	logic             out_valid_q;
	out_t             res_q;

	logic [CNT_W:0]      lo_w_sum, lo_2w_sum;
	logic [CNT_W-1:0]    mid_c, hi_c, i_inc, j_inc;
	logic [VALUE_BITS-1:0] a_rd0, a_rd1, b_rd0, b_rd1, head0, head1, wdata;
	logic                take_left;
	logic [CNT_W-1:0]    raddr0, raddr1, waddr;
	logic                we_a, we_b;
	logic [INV_W:0]      acc_sum;
	logic [INV_W-1:0]    acc_next;

	assign lo_w_sum  = {1'b0, lo_q} + {1'b0, w_q};
	assign lo_2w_sum = {1'b0, lo_q} + {w_q, 1'b0};
	assign mid_c = (lo_w_sum  >= {1'b0, n_q}) ? n_q : lo_w_sum[CNT_W-1:0];
	assign hi_c  = (lo_2w_sum >= {1'b0, n_q}) ? n_q : lo_2w_sum[CNT_W-1:0];
	assign i_inc = i_q + CNT_W'(1);
	assign j_inc = j_q + CNT_W'(1);

	assign head0 = pass_q ? b_rd0 : a_rd0;
	assign head1 = pass_q ? b_rd1 : a_rd1;

	// right run empty, or left run live and not greater (ties go left)
	assign take_left = (j_q >= hi_q) || ((i_q < mid_q) && (head0 <= head1));

	// read addresses run one ahead so the heads arrive for the next step
	always_comb begin
		if (cmd.blk_init) begin
			raddr0 = lo_q;
			raddr1 = mid_c;
		end else begin
			raddr0 = take_left ? i_inc : i_q;
			raddr1 = take_left ? j_q : j_inc;
		end
	end

	assign waddr = cmd.load ? n_q : k_q;
	assign wdata = cmd.load ? (VALUE_BITS'(in_data.value) ^ SIGN_FLIP)
	                        : (take_left ? head0 : head1);
	assign we_a  = (cmd.load && (n_q < CNT_W'(DEPTH))) || (cmd.step && pass_q);
	assign we_b  = cmd.step && !pass_q;

	assign acc_sum  = {1'b0, acc_q} + (INV_W+1)'(mid_q - i_q);
	assign acc_next = acc_sum[INV_W] ? {INV_W{1'b1}} : acc_sum[INV_W-1:0];

	icnt_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_store_a (
		.clk    (clk),
		.we     (we_a),
		.waddr  (waddr[ADDR_W-1:0]),
		.wdata  (wdata),
		.raddr0 (raddr0[ADDR_W-1:0]),
		.raddr1 (raddr1[ADDR_W-1:0]),
		.rdata0 (a_rd0),
		.rdata1 (a_rd1)
	);

	icnt_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_store_b (
		.clk    (clk),
		.we     (we_b),
		.waddr  (waddr[ADDR_W-1:0]),
		.wdata  (wdata),
		.raddr0 (raddr0[ADDR_W-1:0]),
		.raddr1 (raddr1[ADDR_W-1:0]),
		.rdata0 (b_rd0),
		.rdata1 (b_rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			ovf_q       <= 1'b0;
			acc_q       <= '0;
			w_q         <= '0;
			pass_q      <= 1'b0;
			lo_q        <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (n_q < CNT_W'(DEPTH)) begin
					n_q <= n_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.start) begin
				w_q    <= CNT_W'(1);
				pass_q <= 1'b0;
			end
			if (cmd.pass_init) begin
				lo_q <= '0;
			end
			if (cmd.blk_init) begin
				mid_q <= mid_c;
				hi_q  <= hi_c;
				i_q   <= lo_q;
				j_q   <= mid_c;
				k_q   <= lo_q;
			end
			if (cmd.step) begin
				k_q <= k_q + CNT_W'(1);
				if (take_left) begin
					i_q <= i_inc;
				end else begin
					j_q   <= j_inc;
					acc_q <= acc_next;
				end
				if (sts.blk_end) begin
					lo_q <= lo_2w_sum[CNT_W-1:0];
				end
			end
			if (cmd.pass_adv) begin
				w_q    <= {w_q[CNT_W-2:0], 1'b0};
				pass_q <= !pass_q;
			end
			if (cmd.finish) begin
				n_q         <= '0;
				ovf_q       <= 1'b0;
				acc_q       <= '0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.inversions <= acc_q;
			res_q.overflow   <= ovf_q;
		end
	end

	assign sts.pass_done = (w_q >= n_q);
	assign sts.last_blk  = (lo_2w_sum >= {1'b0, n_q});
	assign sts.blk_end   = ((k_q + CNT_W'(1)) == hi_q);
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign out_data  = res_q;
	assign out_valid = out_valid_q;

endmodule

>>> src/icnt_ctrl.sv
// ----------------------------------------------------------------------------
// icnt_ctrl
// Sequencer for load, bottom-up merge passes and result hand-off.
// ----------------------------------------------------------------------------
module icnt_ctrl
	import icnt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.start = 1'b1;
						state_d   = ST_PASS;
					end
				end
			end
			ST_PASS: begin
				if (sts.pass_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.pass_init = 1'b1;
					state_d       = ST_BLK;
				end
			end
			ST_BLK: begin
				cmd.blk_init = 1'b1;
				state_d      = ST_MERGE;
			end
			ST_MERGE: begin
				cmd.step = 1'b1;
				if (sts.blk_end) begin
					if (sts.last_blk) begin
						cmd.pass_adv = 1'b1;
						state_d      = ST_PASS;
					end else begin
						state_d = ST_BLK;
					end
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

>>> src/icnt_checker.sv
// ----------------------------------------------------------------------------
// icnt_checker
// Port-level checks on the inversion counter handshakes and sequencing.
// ----------------------------------------------------------------------------
module icnt_checker
	import icnt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// held result must not move while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// while loading, no new result can be latched, so valid drops after a transfer
	a_out_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && in_ready |=> !out_valid)
		else $error("result repeated after transfer");

	// closing a sequence stops input while the merge runs
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last |=> !in_ready)
		else $error("input taken straight after last");

	// a result only appears at the end of a busy period
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without preceding merge");

endmodule

bind inversion_counter_core icnt_checker u_icnt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

>>> dv/inversion_counter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inversion_counter_core_tb
// Sequences of signed values are streamed in under random flow control, and
// each count that comes back is checked against a pairwise count kept here.
// ----------------------------------------------------------------------------
// Covers single elements, ties, the extremes of the value range, sorted and
// reversed runs, a full-depth set, a set that overruns the store (with the
// dropped element carrying the last mark), then random sets of mixed size.
module inversion_counter_core_tb;
	import icnt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 50;

	localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

	typedef enum {VAL_FULL, VAL_NARROW, VAL_EXTREME} val_mode_t;
	typedef enum {ORD_RANDOM, ORD_ASC, ORD_DESC} ord_mode_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	// predictor state for the sequence being loaded
	logic signed [VALUE_BITS-1:0] loaded_vals[$];
	logic                         dropped_seen;
	out_t                         count_expect_q[$];

	// stimulus under construction
	logic signed [VALUE_BITS-1:0] seq_vals[$];

	int send_idle_pct;
	int recv_idle_pct;
	int fail_cnt;
	int item_cnt;
	int seq_cnt;
	int ovf_seq_cnt;
	int result_cnt;
	int cycle_cnt;
	out_t expected_res;

	inversion_counter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// pairwise count of earlier > later, ties not counted
	task automatic note_accepted(input in_t it);
		longint unsigned total;
		out_t res;
		if (loaded_vals.size() < DEPTH)
			loaded_vals.push_back(it.value);
		else
			dropped_seen = 1'b1;
		item_cnt++;
		if (it.last) begin
			total = 0;
			for (int i = 0; i < loaded_vals.size(); i++)
				for (int j = i + 1; j < loaded_vals.size(); j++)
					if (loaded_vals[i] > loaded_vals[j])
						total++;
			res.inversions = (total > longint'({INV_W{1'b1}})) ? '1 : total[INV_W-1:0];
			res.overflow   = dropped_seen;
			count_expect_q.push_back(res);
			seq_cnt++;
			if (dropped_seen)
				ovf_seq_cnt++;
			loaded_vals.delete();
			dropped_seen = 1'b0;
		end
	endtask

	task automatic send_item(input in_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		note_accepted(it);
	endtask

	task automatic send_sequence();
		in_t it;
		for (int i = 0; i < seq_vals.size(); i++) begin
			it.value = seq_vals[i];
			it.last  = (i == seq_vals.size() - 1);
			send_item(it);
		end
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (count_expect_q.size() != 0);
	endtask

	function automatic logic signed [VALUE_BITS-1:0] pick_value(input val_mode_t m);
		int v;
		case (m)
			VAL_NARROW: begin
				v = $urandom_range(0, 6);
				return v - 3;
			end
			VAL_EXTREME: begin
				case ($urandom_range(0, 6))
					0: return VAL_MIN;
					1: return VAL_MIN + 1;
					2: return -1;
					3: return 0;
					4: return 1;
					5: return VAL_MAX - 1;
					default: return VAL_MAX;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic build_sequence(input int len, input val_mode_t vm, input ord_mode_t om);
		seq_vals.delete();
		repeat (len)
			seq_vals.push_back(pick_value(vm));
		if (om == ORD_ASC)
			seq_vals.sort();
		else if (om == ORD_DESC)
			seq_vals.rsort();
	endtask

	task automatic test_directed();
		seq_vals = '{VAL_MIN};
		send_sequence();
		seq_vals = '{VAL_MIN, VAL_MAX};
		send_sequence();
		seq_vals = '{VAL_MAX, VAL_MIN};
		send_sequence();
		seq_vals = '{-1, -1};
		send_sequence();
		// strictly decreasing: every pair counts
		seq_vals = '{VAL_MAX, 100, 1, 0, -1, -100, VAL_MIN + 1, VAL_MIN};
		send_sequence();
		seq_vals = '{7, 7, 7, 7, 7};
		send_sequence();
		seq_vals = '{0, VAL_MIN, VAL_MAX, 0, -1};
		send_sequence();
		wait_drain();
	endtask

	task automatic test_full_depth();
		build_sequence(DEPTH, VAL_FULL, ORD_RANDOM);
		send_sequence();
		wait_drain();
	endtask

	// overrun: first DEPTH kept in descending order, the rest dropped incl. the last
	task automatic test_overflow();
		seq_vals.delete();
		for (int i = 0; i < DEPTH + 6; i++)
			seq_vals.push_back(VAL_MAX - i);
		send_sequence();
		wait_drain();
	endtask

	task automatic test_random(input int n_items);
		int sent;
		int r;
		int len;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				len = $urandom_range(1, 12);
			else if (r < 95)
				len = $urandom_range(13, 64);
			else
				len = $urandom_range(65, 200);
			build_sequence(len, val_mode_t'($urandom_range(0, 2)),
				ord_mode_t'($urandom_range(0, 2)));
			send_sequence();
			sent += len;
		end
		wait_drain();
	endtask

	// receiver side
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (count_expect_q.size() == 0) begin
				$error("unexpected result transfer: inversions=%0d overflow=%0d",
					out_data.inversions, out_data.overflow);
				fail_cnt++;
			end else begin
				expected_res = count_expect_q.pop_front();
				result_cnt++;
				if (out_data.inversions !== expected_res.inversions) begin
					$error("inversions: expected %0d, got %0d",
						expected_res.inversions, out_data.inversions);
					fail_cnt++;
				end
				if (out_data.overflow !== expected_res.overflow) begin
					$error("overflow: expected %0d, got %0d",
						expected_res.overflow, out_data.overflow);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, count_expect_q.size());
			$display("inversion_counter_core: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		in_data       <= '0;
		out_ready     <= 1'b0;
		dropped_seen  = 1'b0;
		send_idle_pct = 26;
		recv_idle_pct = 70;
		fail_cnt      = 0;
		item_cnt      = 0;
		seq_cnt       = 0;
		ovf_seq_cnt   = 0;
		result_cnt    = 0;
		cycle_cnt     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(233);

		send_idle_pct = 70;
		recv_idle_pct = 26;
		test_full_depth();
		test_overflow();
		test_random(233);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(234);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d elements in %0d sequences, %0d of them overrunning the store.",
			item_cnt, seq_cnt, ovf_seq_cnt);
		$display("Checked %0d counts over %0d cycles, %0d field errors.",
			result_cnt, cycle_cnt, fail_cnt);
		if (fail_cnt == 0 && count_expect_q.size() == 0)
			$display("inversion_counter_core: match");
		else
			$display("inversion_counter_core: mismatch");
		$finish;
	end

endmodule

>>> sim.f
src/icnt_pkg.sv
src/icnt_ram.sv
src/icnt_datapath.sv
src/icnt_ctrl.sv
src/inversion_counter_core.sv
src/icnt_checker.sv
dv/inversion_counter_core_tb.sv
